### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ACM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ACM_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define ACM_ASSERT(label, clk, rst, prop)
`define ACM_ASSERT_NR(label, clk, prop)
`endif

`endif

### rtl/core/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants of the acceleration change magnitude unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SHIFT_W     = 4;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd14;
  localparam int COUNTS_W    = 17;
  localparam int G_W         = 22;
  localparam int SQUARE_W    = 2 * SAMPLE_W;
  localparam int SUM_W       = SQUARE_W + 2;
  localparam int RAD_W       = 2 * G_W;
  localparam int MAX_LSHIFT  = 2 * FRAC_BITS;
  localparam int WIDE_W      = SUM_W + MAX_LSHIFT;
  localparam int LSHIFT_W    = $clog2(MAX_LSHIFT + 1);
  localparam int REM_W       = G_W + 3;
  localparam int ROOT_STEPS  = G_W;
  localparam int AXES        = 3;
  localparam int AXIS_W      = 2;
  localparam int CNT_W       = $clog2(ROOT_STEPS);

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic [COUNTS_W-1:0] change_counts;
    logic [G_W-1:0]      change_g;
  } result_t;

  typedef struct packed {
    logic              capture;
    logic              square;
    logic [AXIS_W-1:0] axis;
    logic              load;
    logic              step;
    logic              publish;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/acm_ctrl.sv
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer that steps the datapath through capture, squaring, root
// iterations and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module acm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  acm_pkg::status_t  status,
  output acm_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [acm_pkg::CNT_W-1:0] cnt;
  logic [acm_pkg::CNT_W-1:0] cnt_next;

  assign sample_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        cmd.axis   = cnt[acm_pkg::AXIS_W-1:0];
        if (cnt == acm_pkg::CNT_W'(acm_pkg::AXES - 1)) begin
          cnt_next   = '0;
          state_next = ST_LOAD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.step = 1'b1;
        if (cnt == acm_pkg::CNT_W'(acm_pkg::ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (status.slot_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `ACM_ASSERT(a_accept_starts_square, clk, rst, (sample_valid && sample_ready) |=> (state == ST_SQUARE && cnt == '0))
  `ACM_ASSERT(a_load_starts_root, clk, rst, (state == ST_LOAD) |=> (state == ST_ROOT && cnt == '0))
  `ACM_ASSERT(a_root_count_bound, clk, rst, (state == ST_ROOT) |-> (cnt < acm_pkg::CNT_W'(acm_pkg::ROOT_STEPS)))

endmodule

`default_nettype wire

### rtl/core/acm_datapath.sv
// ----------------------------------------------------------------------------
// acm_datapath
// Axis differences, shared squarer with accumulator, two bit-per-cycle
// square root lanes and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  acm_pkg::cmd_t                      cmd,
  output acm_pkg::status_t                   status,
  input  acm_pkg::sample_t                   sample,
  input  logic [acm_pkg::SHIFT_W-1:0]        sens_shift,
  output logic                               result_valid,
  input  logic                               result_ready,
  output acm_pkg::result_t                   result
);

  typedef struct packed {
    logic [acm_pkg::REM_W-1:0] rem;
    logic [acm_pkg::G_W-1:0]   root;
    logic [acm_pkg::RAD_W-1:0] rad;
  } lane_t;

  function automatic logic [acm_pkg::SAMPLE_W-1:0] abs_diff(
    input logic signed [acm_pkg::SAMPLE_W-1:0] a,
    input logic signed [acm_pkg::SAMPLE_W-1:0] b
  );
    logic signed [acm_pkg::SAMPLE_W:0] d;
    logic signed [acm_pkg::SAMPLE_W:0] n;
    d = {a[acm_pkg::SAMPLE_W-1], a} - {b[acm_pkg::SAMPLE_W-1], b};
    n = -d;
    return d[acm_pkg::SAMPLE_W] ? n[acm_pkg::SAMPLE_W-1:0] : d[acm_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic lane_t sqrt_step(input lane_t cur);
    lane_t                     nxt;
    logic [acm_pkg::REM_W-1:0] acc;
    logic [acm_pkg::REM_W-1:0] trial;
    acc     = {cur.rem[acm_pkg::REM_W-3:0], cur.rad[acm_pkg::RAD_W-1 -: 2]};
    trial   = {1'b0, cur.root, 2'b01};
    nxt.rad = {cur.rad[acm_pkg::RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      nxt.rem  = acc - trial;
      nxt.root = {cur.root[acm_pkg::G_W-2:0], 1'b1};
    end else begin
      nxt.rem  = acc;
      nxt.root = {cur.root[acm_pkg::G_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic signed [acm_pkg::SAMPLE_W-1:0] last_x;
  logic signed [acm_pkg::SAMPLE_W-1:0] last_y;
  logic signed [acm_pkg::SAMPLE_W-1:0] last_z;
  logic [acm_pkg::SAMPLE_W-1:0]        abs_x;
  logic [acm_pkg::SAMPLE_W-1:0]        abs_y;
  logic [acm_pkg::SAMPLE_W-1:0]        abs_z;
  logic [acm_pkg::SAMPLE_W-1:0]        abs_sel;
  logic [acm_pkg::SQUARE_W-1:0]        square;
  logic [acm_pkg::SUM_W-1:0]           sum;
  logic [acm_pkg::LSHIFT_W-1:0]        lshift;
  logic [acm_pkg::WIDE_W-1:0]          wide;
  lane_t                               lane_c;
  lane_t                               lane_g;
  logic                                sat_g;

  always_comb begin
    case (cmd.axis)
      acm_pkg::AXIS_X: abs_sel = abs_x;
      acm_pkg::AXIS_Y: abs_sel = abs_y;
      acm_pkg::AXIS_Z: abs_sel = abs_z;
      default:         abs_sel = '0;
    endcase
  end

  assign square = abs_sel * abs_sel;
  assign lshift = acm_pkg::LSHIFT_W'(2 * (acm_pkg::FRAC_BITS - 32'(sens_shift)));
  assign wide   = acm_pkg::WIDE_W'(sum) << lshift;

  assign status.slot_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= '0;
      last_y       <= '0;
      last_z       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        last_x <= sample.accel_x;
        last_y <= sample.accel_y;
        last_z <= sample.accel_z;
      end
      if (cmd.publish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      abs_x <= abs_diff(sample.accel_x, last_x);
      abs_y <= abs_diff(sample.accel_y, last_y);
      abs_z <= abs_diff(sample.accel_z, last_z);
      sum   <= '0;
    end
    if (cmd.square) begin
      sum <= sum + acm_pkg::SUM_W'(square);
    end
    if (cmd.load) begin
      lane_c.rem  <= '0;
      lane_c.root <= '0;
      lane_c.rad  <= acm_pkg::RAD_W'(sum);
      lane_g.rem  <= '0;
      lane_g.root <= '0;
      lane_g.rad  <= wide[acm_pkg::RAD_W-1:0];
      sat_g       <= |wide[acm_pkg::WIDE_W-1:acm_pkg::RAD_W];
    end
    if (cmd.step) begin
      lane_c <= sqrt_step(lane_c);
      lane_g <= sqrt_step(lane_g);
    end
    if (cmd.publish) begin
      result.change_counts <= lane_c.root[acm_pkg::COUNTS_W-1:0];
      result.change_g      <= sat_g ? '1 : lane_g.root;
    end
  end

endmodule

`default_nettype wire

### rtl/core/accel_change_magnitude_unit.sv
// ----------------------------------------------------------------------------
// accel_change_magnitude_unit
// Magnitude of the change between successive three-axis samples, in counts
// and in g, with an APB register for the sensitivity shift.
// ----------------------------------------------------------------------------
// Each accepted sample is compared with the previous one (zero after reset);
// the result gives the floor square root of the summed squared differences
// in counts, and the same magnitude in g with 16 fractional bits, saturated
// when it does not fit. After a sample is accepted, its three axis differences go in turn
// through the shared 16 by 16 squarer; a load step and 22 iterations of the
// bit-per-cycle square root follow, and then the output register is written once
// it is free. A new sample is taken in the cycle after the result is registered,
// so the unit does not take a new sample while one is still in progress. The
// sensitivity register, at byte address 0, resets to 14 and should only be
// written while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module accel_change_magnitude_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  acm_pkg::sample_t    sample,
  output logic                result_valid,
  input  logic                result_ready,
  output acm_pkg::result_t    result
);

  localparam logic REG_SENS_SHIFT = 1'b0;

  logic [acm_pkg::SHIFT_W-1:0] sens_shift;
  logic                        reg_write;
  acm_pkg::cmd_t               cmd;
  acm_pkg::status_t            status;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SENS_SHIFT) ? 32'(sens_shift) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_shift <= acm_pkg::SHIFT_RESET;
    end else if (reg_write && paddr[2] == REG_SENS_SHIFT) begin
      sens_shift <= pwdata[acm_pkg::SHIFT_W-1:0];
    end
  end

  acm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  acm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .sens_shift   (sens_shift),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

### dv/accel_change_magnitude_unit_tb.sv
// ----------------------------------------------------------------------------
// accel_change_magnitude_unit_tb
// Self-checking testbench for the acceleration change magnitude unit.
// ----------------------------------------------------------------------------
// A queue of samples, filled phase by phase, feeds a clocked driver. For each
// accepted sample the driver computes the expected change in counts and in
// g from its own copy of the kept sample and the sensitivity shift. A clocked
// monitor checks every result transaction against the oldest expectation.
// Between phases the sensitivity register is rewritten over APB and read
// back; the settings cover the stated range, values above it, and values
// below it that drive the g result into saturation. Both channels idle and
// stall in random bursts, except during the final phase.
`timescale 1ns / 1ps

module accel_change_magnitude_unit_tb;

  localparam logic [2:0] ADDR_SENS_SHIFT = 3'd0;
  localparam int         SETTLE_CYCLES   = 40;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  acm_pkg::sample_t  sample       = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  acm_pkg::result_t  result;

  acm_pkg::sample_t pending_samples[$];
  acm_pkg::result_t expected_changes[$];

  logic signed [acm_pkg::SAMPLE_W-1:0] kept_x = '0;
  logic signed [acm_pkg::SAMPLE_W-1:0] kept_y = '0;
  logic signed [acm_pkg::SAMPLE_W-1:0] kept_z = '0;
  logic [acm_pkg::SHIFT_W-1:0]         sens_shift_model = acm_pkg::SHIFT_RESET;
  acm_pkg::sample_t                    last_queued = '0;

  int  queued_count  = 0;
  int  checked_count = 0;
  int  error_count   = 0;
  int  send_gap      = 0;
  int  recv_stall    = 0;
  bit  quiet         = 1'b0;

  accel_change_magnitude_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root  = 0;
    longint unsigned probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Computes the expected change for one accepted sample and keeps the sample.
  function automatic acm_pkg::result_t predict_change(input acm_pkg::sample_t s);
    longint           dx;
    longint           dy;
    longint           dz;
    longint unsigned  sum;
    longint unsigned  root;
    longint unsigned  g;
    longint unsigned  gmax;
    int               e2;
    acm_pkg::result_t r;
    dx   = longint'($signed(s.accel_x)) - longint'(kept_x);
    dy   = longint'($signed(s.accel_y)) - longint'(kept_y);
    dz   = longint'($signed(s.accel_z)) - longint'(kept_z);
    sum  = dx * dx + dy * dy + dz * dz;
    root = floor_sqrt(sum);
    gmax = (64'd1 << acm_pkg::G_W) - 1;
    if (int'(sens_shift_model) >= acm_pkg::FRAC_BITS) begin
      g = root >> (int'(sens_shift_model) - acm_pkg::FRAC_BITS);
    end else begin
      e2 = 2 * (acm_pkg::FRAC_BITS - int'(sens_shift_model));
      if (sum >= ((64'd1 << acm_pkg::RAD_W) >> e2)) g = gmax;
      else g = floor_sqrt(sum << e2);
    end
    r.change_counts = root[acm_pkg::COUNTS_W-1:0];
    r.change_g      = g[acm_pkg::G_W-1:0];
    kept_x = s.accel_x;
    kept_y = s.accel_y;
    kept_z = s.accel_z;
    return r;
  endfunction

  always @(posedge clk) begin : sample_driver
    logic             nxt_valid;
    acm_pkg::sample_t nxt;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      nxt_valid = sample_valid;
      nxt       = sample;
      if (sample_valid && sample_ready) begin
        expected_changes.push_back(predict_change(sample));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
        end else if (pending_samples.size() > 0) begin
          nxt       = pending_samples.pop_front();
          nxt_valid = 1'b1;
        end
      end
      sample_valid <= nxt_valid;
      sample       <= nxt;
    end
  end

  always @(posedge clk) begin : result_monitor
    acm_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_changes.size() == 0) begin
          $error("result transaction with no expectation waiting");
          error_count++;
        end else begin
          want = expected_changes.pop_front();
          if (result.change_counts !== want.change_counts) begin
            $error("change_counts: expected %0d, got %0d",
                   want.change_counts, result.change_counts);
            error_count++;
          end
          if (result.change_g !== want.change_g) begin
            $error("change_g: expected %0d, got %0d", want.change_g, result.change_g);
            error_count++;
          end
          checked_count++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        result_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 18) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input logic signed [acm_pkg::SAMPLE_W-1:0] x,
                              input logic signed [acm_pkg::SAMPLE_W-1:0] y,
                              input logic signed [acm_pkg::SAMPLE_W-1:0] z);
    acm_pkg::sample_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    pending_samples.push_back(s);
    last_queued = s;
    queued_count++;
  endtask

  task automatic queue_delta(input int dx, input int dy, input int dz);
    queue_sample(acm_pkg::SAMPLE_W'(int'($signed(last_queued.accel_x)) + dx),
                 acm_pkg::SAMPLE_W'(int'($signed(last_queued.accel_y)) + dy),
                 acm_pkg::SAMPLE_W'(int'($signed(last_queued.accel_z)) + dz));
  endtask

  task automatic queue_random_samples(input int n);
    int                                  mode;
    int                                  span;
    logic signed [acm_pkg::SAMPLE_W-1:0] v[acm_pkg::AXES];
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      v[0] = last_queued.accel_x;
      v[1] = last_queued.accel_y;
      v[2] = last_queued.accel_z;
      case ($urandom_range(0, 3))
        0: span = 1;
        1: span = 16;
        2: span = 256;
        default: span = 4096;
      endcase
      for (int a = 0; a < acm_pkg::AXES; a++) begin
        if (mode <= 3) begin
          v[a] = acm_pkg::SAMPLE_W'($urandom());
        end else if (mode <= 6) begin
          v[a] = acm_pkg::SAMPLE_W'(int'(v[a]) + int'($urandom_range(0, 2 * span)) - span);
        end else if (mode == 8) begin
          case ($urandom_range(0, 2))
            0: v[a] = 16'sh7fff;
            1: v[a] = 16'sh8000;
            default: v[a] = '0;
          endcase
        end
      end
      if (mode == 9) v[$urandom_range(0, acm_pkg::AXES - 1)] = acm_pkg::SAMPLE_W'($urandom());
      queue_sample(v[0], v[1], v[2]);
    end
  endtask

  task automatic wait_idle();
    while (checked_count != queued_count) @(posedge clk);
  endtask

  task automatic write_sens_shift(input logic [acm_pkg::SHIFT_W-1:0] val);
    logic [31:0] data;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    data          = $urandom();
    data[acm_pkg::SHIFT_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SENS_SHIFT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sens_shift_model = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[acm_pkg::SHIFT_W-1:0] !== val) begin
      $error("sens_shift: expected %0d, got %0d", val, prdata[acm_pkg::SHIFT_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [acm_pkg::SHIFT_W-1:0] shift_plan[10] = '{4'd12, 4'd13, 4'd11, 4'd14, 4'd15,
                                                    4'd10, 4'd0, 4'd7, 4'd11, 4'd13};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset sensitivity; the first sample is measured against zero.
    queue_sample(16'sh8000, 16'sh7fff, 16'sh0000);
    queue_sample(16'sh8000, 16'sh7fff, 16'sh0000);
    queue_sample(16'sh7fff, 16'sh8000, 16'sh8000);
    queue_sample(16'sh8000, 16'sh7fff, 16'sh7fff);
    queue_delta(1, 0, 0);
    queue_delta(0, -1, 0);
    queue_delta(0, 0, -1);
    queue_sample(16'sd0, 16'sd0, 16'sd0);
    queue_sample(16'sd3, 16'sd4, 16'sd12);

    write_sens_shift(4'd11);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_delta(-1, 0, 0);

    // A shift above the stated range.
    write_sens_shift(4'd15);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);

    // Below the range the g result saturates once it no longer fits.
    write_sens_shift(4'd0);
    queue_sample(16'sd0, 16'sd0, 16'sd0);
    queue_sample(16'sd64, 16'sd0, 16'sd0);
    queue_sample(16'sd1, 16'sd11, 16'sd2);
    queue_sample(16'sd0, 16'sd0, 16'sd0);

    write_sens_shift(4'd10);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_delta(-1, -1, -1);

    foreach (shift_plan[i]) begin
      write_sens_shift(shift_plan[i]);
      queue_random_samples(180);
    end

    write_sens_shift(4'd12);
    quiet = 1'b1;
    queue_random_samples(200);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_changes.size() != 0) begin
      $error("%0d expected result transactions never arrived", expected_changes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("accel_change_magnitude_unit regression: pass");
    end else begin
      $display("accel_change_magnitude_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("accel_change_magnitude_unit regression: fail");
    $finish;
  end

endmodule
